// File: src/cds_pkg.sv
// Shared types, constants and calendar helpers for the calendar date stepper.
`default_nettype none

package cds_pkg;

   // Field widths
   localparam int YEAR_BITS     = 14;
   localparam int COUNT_BITS    = 20;
   localparam int DAY_BITS      = 5;
   localparam int MONTH_BITS    = 4;
   localparam int LIMIT_BITS    = 20;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [YEAR_BITS-1:0]  YEAR_MAX  = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = '1;

   // Year mod 400 by restoring subtraction of 400 * 2^k, k from MOD_STEPS-1 down to 0
   localparam int MOD_STEPS    = $clog2(((2 ** YEAR_BITS) - 1) / 400 + 1);
   localparam int MOD_IDX_BITS = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
   localparam int REM_BITS     = 9;
   localparam logic [REM_BITS-1:0] REM_LAST = 9'd399;

   // Register map: register index is paddr bit 2
   localparam logic CSR_IDX_LIMIT = 1'b0;

   // Months and day lengths
   localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
   localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
   localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
   localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
   localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

   localparam logic [DAY_BITS-1:0] DAY_FIRST = 5'd1;
   localparam logic [DAY_BITS-1:0] DAYS_28   = 5'd28;
   localparam logic [DAY_BITS-1:0] DAYS_29   = 5'd29;
   localparam logic [DAY_BITS-1:0] DAYS_30   = 5'd30;
   localparam logic [DAY_BITS-1:0] DAYS_31   = 5'd31;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_LIMIT    = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic                  operation;
      logic [DAY_BITS-1:0]   first_day;
      logic [MONTH_BITS-1:0] first_month;
      logic [YEAR_BITS-1:0]  first_year;
      logic [COUNT_BITS-1:0] day_count;
      logic [DAY_BITS-1:0]   second_day;
      logic [MONTH_BITS-1:0] second_month;
      logic [YEAR_BITS-1:0]  second_year;
   } req_word_type;

   typedef struct packed {
      logic [DAY_BITS-1:0]   result_day;
      logic [MONTH_BITS-1:0] result_month;
      logic [YEAR_BITS-1:0]  result_year;
      logic [COUNT_BITS-1:0] days_between;
      status_type            status;
   } rsp_word_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic mod_second;
      logic cap_first;
      logic cap_second;
      logic step;
      logic finish;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic mod_done;
      logic valid;
      logic stop;
   } dp_status_type;

   // Leap year from the low year bits and the year mod 400
   function automatic logic is_leap(input logic [1:0] y_low, input logic [REM_BITS-1:0] r400);
      logic century;
      century = (r400 == 9'd100) || (r400 == 9'd200) || (r400 == 9'd300);
      return (r400 == '0) || ((y_low == 2'd0) && !century);
   endfunction

   function automatic logic [DAY_BITS-1:0] month_length(input logic [MONTH_BITS-1:0] m,
                                                          input logic leap);
      logic [DAY_BITS-1:0] len;
      case (m) inside
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_30;
         MONTH_FEB: len = leap ? DAYS_29 : DAYS_28;
         default: len = DAYS_31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// File: src/calendar_date_stepper_top.sv
// Top level of the calendar date stepper: controller, datapath and limit register.
//
// A word is taken when start is high and busy is low; its result appears on rsp_word
// for exactly one cycle with rsp_valid high, and the receiver cannot stall it. One
// word is worked at a time. Between the start edge and the result strobe come the
// iterative mod 400 reduction of both years, a date check and the one-day-per-cycle
// stepper, which steps the days (add mode: at most day_count; difference mode: the days
// counted); an invalid date gives its result from the check without stepping. busy
// falls in the cycle the result is shown, and a new word may be started in that same
// cycle. The user must write the difference step limit register over the APB port only
// while busy is low; the block itself does not enforce this.
`default_nettype none

module calendar_date_stepper_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire cds_pkg::req_word_type             req_word,
   output logic                                   rsp_valid,
   output cds_pkg::rsp_word_type                  rsp_word,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [cds_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [cds_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [cds_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                                   csr_pready
);
   import cds_pkg::*;

   logic [LIMIT_BITS-1:0] limit_ff, limit_in;
   logic                  csr_wr;
   ctrl_cmd_type          cmd;
   dp_status_type         stat;

   // Limit register write
   always_comb begin
      csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;
      limit_in = limit_ff;
      if (csr_wr && (csr_paddr[2] == CSR_IDX_LIMIT)) begin
         limit_in = csr_pwdata[LIMIT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Register read
   always_comb begin
      if (csr_paddr[2] == CSR_IDX_LIMIT) begin
         csr_prdata = CSR_DATA_BITS'(limit_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   assign csr_pready = 1'b1;

   cds_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   cds_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .limit     (limit_ff),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

// File: src/cds_yrmod.sv
// Iterative year mod 400 unit, one restoring subtract per cycle.
`default_nettype none

module cds_yrmod (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [cds_pkg::YEAR_BITS-1:0] value,
   output logic                               done,
   output logic [cds_pkg::REM_BITS-1:0]       rem
);
   import cds_pkg::*;

   localparam int W = YEAR_BITS + 1;

   logic [YEAR_BITS-1:0]    rem_ff, rem_in;
   logic [MOD_IDX_BITS-1:0] idx_ff, idx_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [W-1:0]            sub;
   logic [W-1:0]            trial;

   // One trial subtraction of 400 * 2^idx per cycle
   always_comb begin
      sub     = W'(400) << idx_ff;
      trial   = {1'b0, rem_ff} - sub;
      rem_in  = rem_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = value;
         idx_in  = MOD_IDX_BITS'(MOD_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W-1]) begin
            rem_in = trial[YEAR_BITS-1:0];
         end
         if (idx_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      idx_ff <= idx_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff[REM_BITS-1:0];

endmodule

`default_nettype wire

// File: src/cds_datapath.sv
// Datapath: date registers, day stepping, checks and the result word register.
`default_nettype none

module cds_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cds_pkg::req_word_type          req_word,
   input  wire logic [cds_pkg::LIMIT_BITS-1:0] limit,
   input  wire cds_pkg::ctrl_cmd_type          cmd,
   output cds_pkg::dp_status_type              stat,
   output logic                                rsp_valid,
   output cds_pkg::rsp_word_type               rsp_word
);
   import cds_pkg::*;

   logic                  op_ff, op_in;
   logic [DAY_BITS-1:0]   day_ff, day_in, day2_ff, day2_in;
   logic [MONTH_BITS-1:0] mon_ff, mon_in, mon2_ff, mon2_in;
   logic [YEAR_BITS-1:0]  yr_ff, yr_in, yr2_ff, yr2_in;
   logic [COUNT_BITS-1:0] left_ff, left_in, days_ff, days_in, limit_ff, limit_in;
   logic [REM_BITS-1:0]   r400_ff, r400_in, r400b_ff, r400b_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;
   logic                  rsp_valid_ff;

   logic                  mod_done;
   logic [REM_BITS-1:0]   mod_rem;
   logic [YEAR_BITS-1:0]  mod_value;

   logic                  leap1, leap2, valid1, valid2, valid;
   logic [DAY_BITS-1:0]   mlen1, mlen2;
   logic                  at_target, at_max, left_zero, limit_hit, stop;
   logic [31:0]           limit_wide;
   logic [COUNT_BITS-1:0] limit_cap;
   status_type            fin_status;

   // Shared mod 400 unit: first year straight from the request, then the second year
   assign mod_value = cmd.mod_second ? yr2_ff : req_word.first_year;

   cds_yrmod u_yrmod (
      .clock (clock),
      .reset (reset),
      .start (cmd.load | cmd.mod_second),
      .value (mod_value),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   // Date checks
   always_comb begin
      leap1  = is_leap(yr_ff[1:0], r400_ff);
      leap2  = is_leap(yr2_ff[1:0], r400b_ff);
      mlen1  = month_length(mon_ff, leap1);
      mlen2  = month_length(mon2_ff, leap2);
      valid1 = (yr_ff != '0) && (mon_ff >= MONTH_JAN) && (mon_ff <= MONTH_DEC) &&
               (day_ff >= DAY_FIRST) && (day_ff <= mlen1);
      valid2 = (yr2_ff != '0) && (mon2_ff >= MONTH_JAN) && (mon2_ff <= MONTH_DEC) &&
               (day2_ff >= DAY_FIRST) && (day2_ff <= mlen2);
      valid  = valid1 && (!op_ff || valid2);
   end

   // Stop conditions and outcome
   always_comb begin
      at_target = (day_ff == day2_ff) && (mon_ff == mon2_ff) && (yr_ff == yr2_ff);
      at_max    = (mon_ff == MONTH_DEC) && (day_ff == DAYS_31) && (yr_ff == YEAR_MAX);
      left_zero = (left_ff == '0);
      limit_hit = (days_ff >= limit_ff);
      stop      = op_ff ? (at_target || limit_hit || at_max) : (left_zero || at_max);
      if (!valid) begin
         fin_status = STATUS_INVALID;
      end else if (op_ff) begin
         if (at_target) begin
            fin_status = STATUS_OK;
         end else if (limit_hit) begin
            fin_status = STATUS_LIMIT;
         end else begin
            fin_status = STATUS_OVERFLOW;
         end
      end else begin
         fin_status = left_zero ? STATUS_OK : STATUS_OVERFLOW;
      end
   end

   // Limit capped to the count width
   always_comb begin
      limit_wide = 32'(limit);
      if (limit_wide > 32'(COUNT_MAX)) begin
         limit_cap = COUNT_MAX;
      end else begin
         limit_cap = COUNT_BITS'(limit);
      end
   end

   // Next register values
   always_comb begin
      op_in       = op_ff;
      day_in      = day_ff;
      mon_in      = mon_ff;
      yr_in       = yr_ff;
      left_in     = left_ff;
      day2_in     = day2_ff;
      mon2_in     = mon2_ff;
      yr2_in      = yr2_ff;
      days_in     = days_ff;
      limit_in    = limit_ff;
      r400_in     = r400_ff;
      r400b_in    = r400b_ff;
      rsp_word_in = rsp_word_ff;

      if (cmd.load) begin
         op_in    = req_word.operation;
         day_in   = req_word.first_day;
         mon_in   = req_word.first_month;
         yr_in    = req_word.first_year;
         left_in  = req_word.day_count;
         day2_in  = req_word.second_day;
         mon2_in  = req_word.second_month;
         yr2_in   = req_word.second_year;
         days_in  = '0;
         limit_in = limit_cap;
      end
      if (cmd.cap_first) begin
         r400_in = mod_rem;
      end
      if (cmd.cap_second) begin
         r400b_in = mod_rem;
      end

      // One day forward
      if (cmd.step) begin
         if (day_ff >= mlen1) begin
            day_in = DAY_FIRST;
            if (mon_ff == MONTH_DEC) begin
               mon_in  = MONTH_JAN;
               yr_in   = yr_ff + 1'b1;
               r400_in = (r400_ff == REM_LAST) ? '0 : r400_ff + 1'b1;
            end else begin
               mon_in = mon_ff + 1'b1;
            end
         end else begin
            day_in = day_ff + 1'b1;
         end
         if (op_ff) begin
            days_in = days_ff + 1'b1;
         end else begin
            left_in = left_ff - 1'b1;
         end
      end

      if (cmd.finish) begin
         rsp_word_in.result_day   = day_ff;
         rsp_word_in.result_month = mon_ff;
         rsp_word_in.result_year  = yr_ff;
         rsp_word_in.days_between = days_ff;
         rsp_word_in.status       = fin_status;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      day_ff      <= day_in;
      mon_ff      <= mon_in;
      yr_ff       <= yr_in;
      left_ff     <= left_in;
      day2_ff     <= day2_in;
      mon2_ff     <= mon2_in;
      yr2_ff      <= yr2_in;
      days_ff     <= days_in;
      limit_ff    <= limit_in;
      r400_ff     <= r400_in;
      r400b_ff    <= r400b_in;
      rsp_word_ff <= rsp_word_in;
   end

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign stat.mod_done = mod_done;
   assign stat.valid    = valid;
   assign stat.stop     = stop;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word      = rsp_word_ff;

endmodule

`default_nettype wire

// File: src/cds_ctrl.sv
// Controller state machine: sequences load, year reduction, check and stepping.
`default_nettype none

module cds_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire cds_pkg::dp_status_type stat,
   output cds_pkg::ctrl_cmd_type      cmd,
   output logic                       busy
);
   import cds_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MOD1  = 5'b00010,
      ST_MOD2  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_STEP  = 5'b10000
   } fsm_state_type;

   fsm_state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_MOD1;
            end
         end
         ST_MOD1: begin
            if (stat.mod_done) begin
               cmd.cap_first  = 1'b1;
               cmd.mod_second = 1'b1;
               state_in       = ST_MOD2;
            end
         end
         ST_MOD2: begin
            if (stat.mod_done) begin
               cmd.cap_second = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!stat.valid) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (stat.stop) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// File: src/cds_checker.sv
// Port-level checks of the calendar date stepper, bound to the top level.
`default_nettype none

module cds_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   // A taken word keeps the block busy in the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted word");

   // A result is shown only once the block is back in idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // The end of a busy period always comes with its result
   a_fell_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // Results never come in consecutive cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result strobes in a row");

endmodule

bind calendar_date_stepper_top cds_checker u_cds_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

`default_nettype wire
